### src/c8eu_pkg.sv
// Package: shared types, codes and the opcode decoder for the 8-bit execute unit.
`default_nettype none
package c8eu_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] SpReset     = 8'hFD;
  localparam logic [7:0] StatusReset = 8'h24;

  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagB = 4;
  localparam int unsigned FlagU = 5;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_STORE = 2'd1,
    MEM_PUSH  = 2'd2,
    MEM_PULL  = 2'd3
  } mem_act_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_ADC, OP_SBC, OP_AND, OP_ORA, OP_EOR, OP_CMP, OP_CPX, OP_CPY,
    OP_LDA, OP_LDX, OP_LDY, OP_SHA, OP_SHM, OP_INC, OP_DEC, OP_INX, OP_INY,
    OP_DEX, OP_DEY, OP_BIT, OP_BRA, OP_FLG, OP_STA, OP_STX, OP_STY, OP_TRN,
    OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_UNK
  } op_class_e;

  // shift kinds
  typedef enum logic [1:0] {
    SH_ASL = 2'd0,
    SH_LSR = 2'd1,
    SH_ROL = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  typedef struct packed {
    op_class_e  cls;
    logic [2:0] sub;
  } dec_t;

  typedef struct packed {
    dec_t       dec;
    logic [7:0] operand;
  } qitem_t;

  typedef struct packed {
    logic [1:0] mem_action;
    logic [7:0] data_value;
    logic       branch_taken;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] stack_ptr_out;
    logic [7:0] status_out;
    logic       unknown_opcode;
  } result_t;

  // sub codes: shifts use shift_e; branches {flag sel[1:0], want}; flags
  // {set, sel[1:0]} sel 0 C 1 D 2 I 3 V; transfers 0 TAX 1 TAY 2 TSX 3 TXA 4 TYA 5 TXS
  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    d.cls = OP_UNK;
    d.sub = 3'd0;
    unique case (op)
      8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: d.cls = OP_ADC;
      8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: d.cls = OP_SBC;
      8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: d.cls = OP_AND;
      8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: d.cls = OP_ORA;
      8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: d.cls = OP_EOR;
      8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: d.cls = OP_CMP;
      8'hE0, 8'hE4, 8'hEC: d.cls = OP_CPX;
      8'hC0, 8'hC4, 8'hCC: d.cls = OP_CPY;
      8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: d.cls = OP_LDA;
      8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: d.cls = OP_LDX;
      8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: d.cls = OP_LDY;
      8'h0A: begin d.cls = OP_SHA; d.sub = {1'b0, SH_ASL}; end
      8'h4A: begin d.cls = OP_SHA; d.sub = {1'b0, SH_LSR}; end
      8'h2A: begin d.cls = OP_SHA; d.sub = {1'b0, SH_ROL}; end
      8'h6A: begin d.cls = OP_SHA; d.sub = {1'b0, SH_ROR}; end
      8'h06, 8'h16, 8'h0E, 8'h1E: begin d.cls = OP_SHM; d.sub = {1'b0, SH_ASL}; end
      8'h46, 8'h56, 8'h4E, 8'h5E: begin d.cls = OP_SHM; d.sub = {1'b0, SH_LSR}; end
      8'h26, 8'h36, 8'h2E, 8'h3E: begin d.cls = OP_SHM; d.sub = {1'b0, SH_ROL}; end
      8'h66, 8'h76, 8'h6E, 8'h7E: begin d.cls = OP_SHM; d.sub = {1'b0, SH_ROR}; end
      8'hE6, 8'hF6, 8'hEE, 8'hFE: d.cls = OP_INC;
      8'hC6, 8'hD6, 8'hCE, 8'hDE: d.cls = OP_DEC;
      8'hE8: d.cls = OP_INX;
      8'hC8: d.cls = OP_INY;
      8'hCA: d.cls = OP_DEX;
      8'h88: d.cls = OP_DEY;
      8'h24, 8'h2C: d.cls = OP_BIT;
      8'h90: begin d.cls = OP_BRA; d.sub = 3'b000; end
      8'hB0: begin d.cls = OP_BRA; d.sub = 3'b001; end
      8'hF0: begin d.cls = OP_BRA; d.sub = 3'b011; end
      8'hD0: begin d.cls = OP_BRA; d.sub = 3'b010; end
      8'h30: begin d.cls = OP_BRA; d.sub = 3'b101; end
      8'h10: begin d.cls = OP_BRA; d.sub = 3'b100; end
      8'h70: begin d.cls = OP_BRA; d.sub = 3'b111; end
      8'h50: begin d.cls = OP_BRA; d.sub = 3'b110; end
      8'h18: begin d.cls = OP_FLG; d.sub = 3'b000; end
      8'hD8: begin d.cls = OP_FLG; d.sub = 3'b001; end
      8'h58: begin d.cls = OP_FLG; d.sub = 3'b010; end
      8'hB8: begin d.cls = OP_FLG; d.sub = 3'b011; end
      8'h38: begin d.cls = OP_FLG; d.sub = 3'b100; end
      8'hF8: begin d.cls = OP_FLG; d.sub = 3'b101; end
      8'h78: begin d.cls = OP_FLG; d.sub = 3'b110; end
      8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91: d.cls = OP_STA;
      8'h86, 8'h96, 8'h8E: d.cls = OP_STX;
      8'h84, 8'h94, 8'h8C: d.cls = OP_STY;
      8'hAA: begin d.cls = OP_TRN; d.sub = 3'd0; end
      8'hA8: begin d.cls = OP_TRN; d.sub = 3'd1; end
      8'hBA: begin d.cls = OP_TRN; d.sub = 3'd2; end
      8'h8A: begin d.cls = OP_TRN; d.sub = 3'd3; end
      8'h98: begin d.cls = OP_TRN; d.sub = 3'd4; end
      8'h9A: begin d.cls = OP_TRN; d.sub = 3'd5; end
      8'h48: d.cls = OP_PHA;
      8'h08: d.cls = OP_PHP;
      8'h68: d.cls = OP_PLA;
      8'h28: d.cls = OP_PLP;
      8'h4C, 8'h6C, 8'h20, 8'h40, 8'h60, 8'h00, 8'hEA: d.cls = OP_NOP;
      default: d.cls = OP_UNK;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### src/c8eu_if.sv
// Interfaces: valid/ready channels for instructions and results.
`default_nettype none
interface c8eu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] operand_value;
  modport source (output valid, output opcode, output operand_value, input ready);
  modport sink (input valid, input opcode, input operand_value, output ready);
endinterface

interface c8eu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mem_action;
  logic [7:0] data_value;
  logic       branch_taken;
  logic [7:0] acc_out;
  logic [7:0] x_out;
  logic [7:0] y_out;
  logic [7:0] stack_ptr_out;
  logic [7:0] status_out;
  logic       unknown_opcode;
  modport source (output valid, output mem_action, output data_value, output branch_taken,
                  output acc_out, output x_out, output y_out, output stack_ptr_out,
                  output status_out, output unknown_opcode, input ready);
  modport sink (input valid, input mem_action, input data_value, input branch_taken,
                input acc_out, input x_out, input y_out, input stack_ptr_out,
                input status_out, input unknown_opcode, output ready);
endinterface
`default_nettype wire

### src/c8eu_queue.sv
// Queue: small FIFO of decoded transactions between front and back.
`default_nettype none
module c8eu_queue #(
  parameter int unsigned Depth = c8eu_pkg::QueueDepth
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  c8eu_pkg::qitem_t    push_data_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                empty_o,
  output c8eu_pkg::qitem_t    pop_data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  c8eu_pkg::qitem_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o     = (cnt_q == (AW+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + (AW+1)'(1)) else $error("count");
`endif
endmodule
`default_nettype wire

### src/c8eu_back.sv
// Back end: register file, ALU and the output register.
`default_nettype none
module c8eu_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_empty_i,
  input  c8eu_pkg::qitem_t   q_data_i,
  output logic               q_pop_o,
  output logic               res_valid_o,
  input  wire                res_ready_i,
  output c8eu_pkg::result_t  res_o
);
  logic [7:0] a_q, x_q, y_q, sp_q, p_q;
  logic [7:0] a_d, x_d, y_d, sp_d, p_d;
  logic       vld_q;
  c8eu_pkg::result_t res_q, res_d;

  c8eu_pkg::op_class_e cls;
  logic [2:0] sub;
  logic [7:0] v, zr, shin, shout, cmp_reg;
  logic [8:0] sum;
  logic [7:0] addend, cmpdiff;
  logic       zset, shc, brf;
  logic [1:0] act;
  logic [7:0] data;

  assign cls = q_data_i.dec.cls;
  assign sub = q_data_i.dec.sub;
  assign v   = q_data_i.operand;

  assign q_pop_o = !q_empty_i && (!vld_q || res_ready_i);

  always_comb begin
    addend  = (cls == c8eu_pkg::OP_SBC) ? ~v : v;
    sum     = {1'b0, a_q} + {1'b0, addend} + {8'd0, p_q[c8eu_pkg::FlagC]};
    cmp_reg = (cls == c8eu_pkg::OP_CPX) ? x_q : (cls == c8eu_pkg::OP_CPY) ? y_q : a_q;
    cmpdiff = cmp_reg - v;
    shin    = (cls == c8eu_pkg::OP_SHA) ? a_q : v;
    case (c8eu_pkg::shift_e'(sub[1:0]))
      c8eu_pkg::SH_ASL: begin shout = {shin[6:0], 1'b0}; shc = shin[7]; end
      c8eu_pkg::SH_LSR: begin shout = {1'b0, shin[7:1]}; shc = shin[0]; end
      c8eu_pkg::SH_ROL: begin shout = {shin[6:0], p_q[c8eu_pkg::FlagC]}; shc = shin[7]; end
      default:          begin shout = {p_q[c8eu_pkg::FlagC], shin[7:1]}; shc = shin[0]; end
    endcase
    case (sub[2:1])
      2'd0:    brf = p_q[c8eu_pkg::FlagC];
      2'd1:    brf = p_q[c8eu_pkg::FlagZ];
      2'd2:    brf = p_q[c8eu_pkg::FlagN];
      default: brf = p_q[c8eu_pkg::FlagV];
    endcase

    a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q;
    act = c8eu_pkg::MEM_NONE; data = 8'd0;
    zr = 8'd0; zset = 1'b0;
    res_d = res_q;

    unique case (cls)
      c8eu_pkg::OP_ADC, c8eu_pkg::OP_SBC: begin
        a_d = sum[7:0]; zr = sum[7:0]; zset = 1'b1;
        p_d[c8eu_pkg::FlagC] = sum[8];
        p_d[c8eu_pkg::FlagV] = (a_q[7] ^ sum[7]) & (addend[7] ^ sum[7]);
      end
      c8eu_pkg::OP_AND: begin a_d = a_q & v; zr = a_d; zset = 1'b1; end
      c8eu_pkg::OP_ORA: begin a_d = a_q | v; zr = a_d; zset = 1'b1; end
      c8eu_pkg::OP_EOR: begin a_d = a_q ^ v; zr = a_d; zset = 1'b1; end
      c8eu_pkg::OP_CMP, c8eu_pkg::OP_CPX, c8eu_pkg::OP_CPY: begin
        p_d[c8eu_pkg::FlagC] = cmp_reg >= v; zr = cmpdiff; zset = 1'b1;
      end
      c8eu_pkg::OP_LDA: begin a_d = v; zr = v; zset = 1'b1; end
      c8eu_pkg::OP_LDX: begin x_d = v; zr = v; zset = 1'b1; end
      c8eu_pkg::OP_LDY: begin y_d = v; zr = v; zset = 1'b1; end
      c8eu_pkg::OP_SHA: begin
        a_d = shout; p_d[c8eu_pkg::FlagC] = shc; zr = shout; zset = 1'b1;
      end
      c8eu_pkg::OP_SHM: begin
        act = c8eu_pkg::MEM_STORE; data = shout;
        p_d[c8eu_pkg::FlagC] = shc; zr = shout; zset = 1'b1;
      end
      c8eu_pkg::OP_INC: begin
        act = c8eu_pkg::MEM_STORE; data = v + 8'd1; zr = data; zset = 1'b1;
      end
      c8eu_pkg::OP_DEC: begin
        act = c8eu_pkg::MEM_STORE; data = v - 8'd1; zr = data; zset = 1'b1;
      end
      c8eu_pkg::OP_INX: begin x_d = x_q + 8'd1; zr = x_d; zset = 1'b1; end
      c8eu_pkg::OP_INY: begin y_d = y_q + 8'd1; zr = y_d; zset = 1'b1; end
      c8eu_pkg::OP_DEX: begin x_d = x_q - 8'd1; zr = x_d; zset = 1'b1; end
      c8eu_pkg::OP_DEY: begin y_d = y_q - 8'd1; zr = y_d; zset = 1'b1; end
      c8eu_pkg::OP_BIT: begin
        p_d[c8eu_pkg::FlagZ] = (a_q & v) == 8'd0;
        p_d[c8eu_pkg::FlagV] = v[6];
        p_d[c8eu_pkg::FlagN] = v[7];
      end
      c8eu_pkg::OP_FLG: begin
        case (sub[1:0])
          2'd0:    p_d[c8eu_pkg::FlagC] = sub[2];
          2'd1:    p_d[c8eu_pkg::FlagD] = sub[2];
          2'd2:    p_d[c8eu_pkg::FlagI] = sub[2];
          default: p_d[c8eu_pkg::FlagV] = sub[2];
        endcase
      end
      c8eu_pkg::OP_STA: begin act = c8eu_pkg::MEM_STORE; data = a_q; end
      c8eu_pkg::OP_STX: begin act = c8eu_pkg::MEM_STORE; data = x_q; end
      c8eu_pkg::OP_STY: begin act = c8eu_pkg::MEM_STORE; data = y_q; end
      c8eu_pkg::OP_TRN: begin
        case (sub)
          3'd0:    begin x_d = a_q;  zr = a_q;  zset = 1'b1; end
          3'd1:    begin y_d = a_q;  zr = a_q;  zset = 1'b1; end
          3'd2:    begin x_d = sp_q; zr = sp_q; zset = 1'b1; end
          3'd3:    begin a_d = x_q;  zr = x_q;  zset = 1'b1; end
          3'd4:    begin a_d = y_q;  zr = y_q;  zset = 1'b1; end
          default: sp_d = x_q;
        endcase
      end
      c8eu_pkg::OP_PHA: begin act = c8eu_pkg::MEM_PUSH; data = a_q; sp_d = sp_q - 8'd1; end
      c8eu_pkg::OP_PHP: begin
        act = c8eu_pkg::MEM_PUSH; sp_d = sp_q - 8'd1;
        data = p_q | 8'h30;
      end
      c8eu_pkg::OP_PLA: begin
        act = c8eu_pkg::MEM_PULL; sp_d = sp_q + 8'd1; a_d = v; zr = v; zset = 1'b1;
      end
      c8eu_pkg::OP_PLP: begin
        act = c8eu_pkg::MEM_PULL; sp_d = sp_q + 8'd1;
        p_d = (v & 8'hEF) | 8'h20;
      end
      default: ;
    endcase

    if (zset) begin
      p_d[c8eu_pkg::FlagZ] = zr == 8'd0;
      p_d[c8eu_pkg::FlagN] = zr[7];
    end

    res_d.mem_action     = act;
    res_d.data_value     = data;
    res_d.branch_taken   = (cls == c8eu_pkg::OP_BRA) && (brf == sub[0]);
    res_d.acc_out        = a_d;
    res_d.x_out          = x_d;
    res_d.y_out          = y_d;
    res_d.stack_ptr_out  = sp_d;
    res_d.status_out     = p_d;
    res_d.unknown_opcode = cls == c8eu_pkg::OP_UNK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= 8'd0;
      x_q   <= 8'd0;
      y_q   <= 8'd0;
      sp_q  <= c8eu_pkg::SpReset;
      p_q   <= c8eu_pkg::StatusReset;
      vld_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d;
        vld_q <= 1'b1;
      end else if (res_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) res_q <= res_d;
  end

  assign res_valid_o = vld_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !res_ready_i) |=> $stable(a_q) && $stable(p_q)) else $error("state moved");
  a_bit5: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_q[c8eu_pkg::FlagU]) else $error("status bit 5 clear");
  a_unk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && res_q.unknown_opcode) |-> res_q.mem_action == c8eu_pkg::MEM_NONE)
    else $error("unknown op with access");
`endif
endmodule
`default_nettype wire

### src/cpu8_execute_unit.sv
// Top level: 6502 execute unit with decoding front, queue and executing back.
//
// Usage: instructions arrive on in_if (opcode plus fetched operand byte);
// one result transaction per instruction leaves on out_if carrying the
// memory/stack action, write data, branch decision, A/X/Y/SP/P after the
// instruction and an unknown-opcode flag.
// Flow: each instruction is decoded into the queue when accepted, then executed
// from the queue into the output register.
// Throughput: one instruction per cycle while out_if.ready stays high, limited
// by the register-file update in the back end.
// Reset: A=X=Y=0, SP=0xFD, P=0x24, queue and output register empty.
// Stall: when out_if.ready is low the output register holds; the back end
// stops, the two-entry queue fills and in_if.ready drops once it is full.
`default_nettype none
module cpu8_execute_unit #(
  parameter int unsigned QueueDepth = c8eu_pkg::QueueDepth
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  c8eu_in_if.sink    in_if,
  c8eu_out_if.source out_if
);
  c8eu_pkg::qitem_t  push_data, pop_data;
  c8eu_pkg::result_t res;
  logic full, empty, pop, push;

  assign in_if.ready = !full;
  assign push        = in_if.valid && !full;
  assign push_data.dec     = c8eu_pkg::decode(in_if.opcode);
  assign push_data.operand = in_if.operand_value;

  c8eu_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data)
  );

  c8eu_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i(empty), .q_data_i(pop_data), .q_pop_o(pop),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready), .res_o(res)
  );

  assign out_if.mem_action     = res.mem_action;
  assign out_if.data_value     = res.data_value;
  assign out_if.branch_taken   = res.branch_taken;
  assign out_if.acc_out        = res.acc_out;
  assign out_if.x_out          = res.x_out;
  assign out_if.y_out          = res.y_out;
  assign out_if.stack_ptr_out  = res.stack_ptr_out;
  assign out_if.status_out     = res.status_out;
  assign out_if.unknown_opcode = res.unknown_opcode;
endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for cpu8_execute_unit: directed and random opcode streams checked against a predictor.
`default_nettype none
module tb;

  typedef struct packed {
    logic [1:0] mem_action;
    logic [7:0] data_value;
    logic       branch_taken;
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
    logic       unknown;
  } exec_result_t;

  localparam int unsigned CycleLimit = 200000;

  logic clk_i;
  logic rst_ni;
  logic idle_off;
  int   fail_count;
  int   cycle_count;

  logic [7:0] a_reg, x_reg, y_reg, sp_reg, p_reg;
  exec_result_t expected_q[$];

  c8eu_in_if  in_if ();
  c8eu_out_if out_if ();

  cpu8_execute_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [7:0] set_zn(input logic [7:0] v);
    p_reg[c8eu_pkg::FlagZ] = (v == 8'h00);
    p_reg[c8eu_pkg::FlagN] = v[7];
    return v;
  endfunction

  function automatic void add_to_acc(input logic [7:0] v);
    logic [8:0] sum;
    sum = {1'b0, a_reg} + {1'b0, v} + {8'd0, p_reg[c8eu_pkg::FlagC]};
    p_reg[c8eu_pkg::FlagC] = sum[8];
    p_reg[c8eu_pkg::FlagV] = (a_reg[7] ^ sum[7]) & (v[7] ^ sum[7]);
    a_reg = set_zn(sum[7:0]);
  endfunction

  function automatic void compare(input logic [7:0] r, input logic [7:0] v);
    p_reg[c8eu_pkg::FlagC] = (r >= v);
    void'(set_zn(r - v));
  endfunction

  function automatic logic [7:0] shift_byte(input c8eu_pkg::shift_e k, input logic [7:0] v);
    logic       cin;
    logic [7:0] r;
    cin = p_reg[c8eu_pkg::FlagC];
    case (k)
      c8eu_pkg::SH_ASL: begin p_reg[c8eu_pkg::FlagC] = v[7]; r = {v[6:0], 1'b0}; end
      c8eu_pkg::SH_LSR: begin p_reg[c8eu_pkg::FlagC] = v[0]; r = {1'b0, v[7:1]}; end
      c8eu_pkg::SH_ROL: begin p_reg[c8eu_pkg::FlagC] = v[7]; r = {v[6:0], cin}; end
      default: begin p_reg[c8eu_pkg::FlagC] = v[0]; r = {cin, v[7:1]}; end
    endcase
    return set_zn(r);
  endfunction

  function automatic exec_result_t execute(input logic [7:0] op, input logic [7:0] v);
    exec_result_t r;
    r = '0;
    case (op)
      8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: add_to_acc(v);
      8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: add_to_acc(~v);
      8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: a_reg = set_zn(a_reg & v);
      8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: a_reg = set_zn(a_reg | v);
      8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: a_reg = set_zn(a_reg ^ v);
      8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: compare(a_reg, v);
      8'hE0, 8'hE4, 8'hEC: compare(x_reg, v);
      8'hC0, 8'hC4, 8'hCC: compare(y_reg, v);
      8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: a_reg = set_zn(v);
      8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: x_reg = set_zn(v);
      8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: y_reg = set_zn(v);
      8'h0A: a_reg = shift_byte(c8eu_pkg::SH_ASL, a_reg);
      8'h4A: a_reg = shift_byte(c8eu_pkg::SH_LSR, a_reg);
      8'h2A: a_reg = shift_byte(c8eu_pkg::SH_ROL, a_reg);
      8'h6A: a_reg = shift_byte(c8eu_pkg::SH_ROR, a_reg);
      8'h06, 8'h16, 8'h0E, 8'h1E: begin
        r.mem_action = c8eu_pkg::MEM_STORE; r.data_value = shift_byte(c8eu_pkg::SH_ASL, v);
      end
      8'h46, 8'h56, 8'h4E, 8'h5E: begin
        r.mem_action = c8eu_pkg::MEM_STORE; r.data_value = shift_byte(c8eu_pkg::SH_LSR, v);
      end
      8'h26, 8'h36, 8'h2E, 8'h3E: begin
        r.mem_action = c8eu_pkg::MEM_STORE; r.data_value = shift_byte(c8eu_pkg::SH_ROL, v);
      end
      8'h66, 8'h76, 8'h6E, 8'h7E: begin
        r.mem_action = c8eu_pkg::MEM_STORE; r.data_value = shift_byte(c8eu_pkg::SH_ROR, v);
      end
      8'hE6, 8'hF6, 8'hEE, 8'hFE: begin
        r.mem_action = c8eu_pkg::MEM_STORE; r.data_value = set_zn(v + 8'd1);
      end
      8'hC6, 8'hD6, 8'hCE, 8'hDE: begin
        r.mem_action = c8eu_pkg::MEM_STORE; r.data_value = set_zn(v - 8'd1);
      end
      8'hE8: x_reg = set_zn(x_reg + 8'd1);
      8'hC8: y_reg = set_zn(y_reg + 8'd1);
      8'hCA: x_reg = set_zn(x_reg - 8'd1);
      8'h88: y_reg = set_zn(y_reg - 8'd1);
      8'h24, 8'h2C: begin
        p_reg[c8eu_pkg::FlagZ] = ((a_reg & v) == 8'h00);
        p_reg[c8eu_pkg::FlagV] = v[6];
        p_reg[c8eu_pkg::FlagN] = v[7];
      end
      8'h90: r.branch_taken = !p_reg[c8eu_pkg::FlagC];
      8'hB0: r.branch_taken = p_reg[c8eu_pkg::FlagC];
      8'hF0: r.branch_taken = p_reg[c8eu_pkg::FlagZ];
      8'hD0: r.branch_taken = !p_reg[c8eu_pkg::FlagZ];
      8'h30: r.branch_taken = p_reg[c8eu_pkg::FlagN];
      8'h10: r.branch_taken = !p_reg[c8eu_pkg::FlagN];
      8'h70: r.branch_taken = p_reg[c8eu_pkg::FlagV];
      8'h50: r.branch_taken = !p_reg[c8eu_pkg::FlagV];
      8'h18: p_reg[c8eu_pkg::FlagC] = 1'b0;
      8'hD8: p_reg[c8eu_pkg::FlagD] = 1'b0;
      8'h58: p_reg[c8eu_pkg::FlagI] = 1'b0;
      8'hB8: p_reg[c8eu_pkg::FlagV] = 1'b0;
      8'h38: p_reg[c8eu_pkg::FlagC] = 1'b1;
      8'hF8: p_reg[c8eu_pkg::FlagD] = 1'b1;
      8'h78: p_reg[c8eu_pkg::FlagI] = 1'b1;
      8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91: begin
        r.mem_action = c8eu_pkg::MEM_STORE; r.data_value = a_reg;
      end
      8'h86, 8'h96, 8'h8E: begin
        r.mem_action = c8eu_pkg::MEM_STORE; r.data_value = x_reg;
      end
      8'h84, 8'h94, 8'h8C: begin
        r.mem_action = c8eu_pkg::MEM_STORE; r.data_value = y_reg;
      end
      8'hAA: x_reg = set_zn(a_reg);
      8'hA8: y_reg = set_zn(a_reg);
      8'hBA: x_reg = set_zn(sp_reg);
      8'h8A: a_reg = set_zn(x_reg);
      8'h98: a_reg = set_zn(y_reg);
      8'h9A: sp_reg = x_reg;
      8'h48: begin
        r.mem_action = c8eu_pkg::MEM_PUSH; r.data_value = a_reg; sp_reg = sp_reg - 8'd1;
      end
      8'h08: begin
        r.mem_action = c8eu_pkg::MEM_PUSH;
        r.data_value = p_reg | (8'd1 << c8eu_pkg::FlagB) | (8'd1 << c8eu_pkg::FlagU);
        sp_reg = sp_reg - 8'd1;
      end
      8'h68: begin
        r.mem_action = c8eu_pkg::MEM_PULL; sp_reg = sp_reg + 8'd1; a_reg = set_zn(v);
      end
      8'h28: begin
        r.mem_action = c8eu_pkg::MEM_PULL;
        sp_reg = sp_reg + 8'd1;
        p_reg = v;
        p_reg[c8eu_pkg::FlagB] = 1'b0;
        p_reg[c8eu_pkg::FlagU] = 1'b1;
      end
      8'h4C, 8'h6C, 8'h20, 8'h40, 8'h60, 8'h00, 8'hEA: ;
      default: r.unknown = 1'b1;
    endcase
    r.acc = a_reg;
    r.x   = x_reg;
    r.y   = y_reg;
    r.sp  = sp_reg;
    r.p   = p_reg;
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // checker and ready generator
  initial begin
    exec_result_t want;
    int gap;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_if.mem_action !== want.mem_action)
            report("mem_action", out_if.mem_action, want.mem_action);
          if (out_if.data_value !== want.data_value)
            report("data_value", out_if.data_value, want.data_value);
          if (out_if.branch_taken !== want.branch_taken)
            report("branch_taken", out_if.branch_taken, want.branch_taken);
          if (out_if.acc_out !== want.acc) report("acc_out", out_if.acc_out, want.acc);
          if (out_if.x_out !== want.x) report("x_out", out_if.x_out, want.x);
          if (out_if.y_out !== want.y) report("y_out", out_if.y_out, want.y);
          if (out_if.stack_ptr_out !== want.sp)
            report("stack_ptr_out", out_if.stack_ptr_out, want.sp);
          if (out_if.status_out !== want.p) report("status_out", out_if.status_out, want.p);
          if (out_if.unknown_opcode !== want.unknown)
            report("unknown_opcode", out_if.unknown_opcode, want.unknown);
        end
      end
      if (gap > 0) begin
        gap--;
        out_if.ready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 7) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(input logic [7:0] op, input logic [7:0] v);
    int gap;
    if (!idle_off && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.opcode        <= op;
    in_if.operand_value <= v;
    expected_q.push_back(execute(op, v));
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic go_idle();
    in_if.valid <= 1'b0;
  endtask

  task automatic test_directed();
    send(8'hA9, 8'h00);  // LDA zero
    send(8'hA9, 8'h80);  // LDA negative
    send(8'h69, 8'h80);  // ADC signed overflow
    send(8'h69, 8'hFF);  // ADC carry out
    send(8'hE9, 8'h7F);  // SBC
    send(8'hC9, 8'hFF);  // CMP below
    send(8'h24, 8'hC0);  // BIT copies N V
    send(8'h70, 8'h00);  // BVS
    send(8'h06, 8'h81);  // memory ASL
    send(8'h66, 8'h01);  // memory ROR
    send(8'hE6, 8'hFF);  // INC wrap
    send(8'hC6, 8'h00);  // DEC wrap
    send(8'h08, 8'h00);  // PHP sets B
    send(8'h28, 8'hFF);  // PLP clears B
    send(8'hF8, 8'h00);  // SED
    send(8'h69, 8'h09);  // ADC stays binary
    send(8'hA2, 8'h00);
    send(8'h9A, 8'h00);  // TXS to 0
    send(8'h68, 8'h55);  // PLA increments sp from 0
    send(8'h48, 8'h00);  // PHA back to 0; the next one wraps
    send(8'h48, 8'h00);
    send(8'hBA, 8'h00);
    send(8'h02, 8'hAA);  // unknown
    send(8'hFF, 8'hFF);  // unknown
    send(8'h00, 8'h00);  // BRK no effect
  endtask

  task automatic test_all_opcodes();
    for (int i = 0; i < 256; i++) send(i[7:0], 8'($urandom));
  endtask

  task automatic test_random(input int n);
    logic [7:0] op;
    for (int i = 0; i < n; i++) begin
      op = 8'($urandom);
      if (i % 4 == 0) op = {3'($urandom_range(0, 7)), 5'h10};  // branches
      send(op, (i % 5 == 0) ? 8'($urandom_range(0, 1) * 8'hFF) : 8'($urandom));
    end
  endtask

  initial begin
    fail_count = 0;
    cycle_count = 0;
    idle_off = 1'b0;
    a_reg = 8'h00;
    x_reg = 8'h00;
    y_reg = 8'h00;
    sp_reg = c8eu_pkg::SpReset;
    p_reg = c8eu_pkg::StatusReset;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = 8'h00;
    in_if.operand_value = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_all_opcodes();
    test_random(700);
    idle_off = 1'b1;
    test_random(150);
    go_idle();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
